>>> hw/rtl/ffn_pkg.sv
package ffn_pkg;

	localparam int CoordW = 24;
	localparam int EdgeW  = 25;
	localparam int CrossW = 51;
	localparam int MagW   = 50;
	localparam int FitW   = 30;
	localparam int SumW   = 62;
	localparam int RootW  = 31;
	localparam int NormW  = 16;
	localparam int IdxW   = 32;
	localparam int QuoW   = 15;
	localparam int NumW   = FitW + QuoW + 1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_MAG,
		ST_SHIFT,
		ST_SQ,
		ST_ROOT,
		ST_DIV,
		ST_EMIT
	} ffn_state_t;

	typedef logic signed [CoordW-1:0] coord_t;
	typedef logic signed [NormW-1:0]  norm_t;

endpackage

>>> hw/rtl/ffn_serial_mul.sv
module ffn_serial_mul #(
	parameter int AW = 32,
	parameter int BW = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [AW-1:0]      a,
	input  logic [BW-1:0]      b,
	output logic               done,
	output logic [AW+BW-1:0]   p
);
	localparam int CW = $clog2(BW + 1);

	logic [AW+BW-1:0] acc_q;
	logic [AW+BW-1:0] a_q;
	logic [BW-1:0]    b_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(BW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= {{BW{1'b0}}, a};
			b_q   <= b;
		end else if (busy_q) begin
			if (b_q[0]) acc_q <= acc_q + a_q;
			a_q <= a_q << 1;
			b_q <= b_q >> 1;
		end
	end

	// last partial product folded in on the done cycle
	assign done = busy_q && cnt_q == CW'(1);
	assign p    = acc_q + (b_q[0] ? a_q : '0);
endmodule

>>> hw/rtl/flat_face_normal_unit.sv
// Flat face normal: one triangle in (three Q12.12 corners), three vertices out
// (A, B, Q) with the shared Q1.14 unit normal and a running 32-bit index.
// Everything runs bit-serially through one shift-add multiplier, a
// restoring square root (one result bit per cycle) and a restoring divider
// (one quotient bit per cycle); an item passes through the six 25-bit
// cross-product multiplies, the range shifting, three 30-bit squares, the
// 31-step root and three 46-step divides before its first vertex (a
// degenerate triangle goes straight from the cross product to output). One
// triangle is in flight at a time; the three results then leave one per
// accepted cycle.
module flat_face_normal_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  ffn_pkg::coord_t               ax,
	input  ffn_pkg::coord_t               ay,
	input  ffn_pkg::coord_t               az,
	input  ffn_pkg::coord_t               bx,
	input  ffn_pkg::coord_t               by,
	input  ffn_pkg::coord_t               bz,
	input  ffn_pkg::coord_t               qx,
	input  ffn_pkg::coord_t               qy,
	input  ffn_pkg::coord_t               qz,
	input  logic                          new_mesh,
	output logic                          out_valid,
	input  logic                          out_ready,
	output ffn_pkg::coord_t               pos_x,
	output ffn_pkg::coord_t               pos_y,
	output ffn_pkg::coord_t               pos_z,
	output ffn_pkg::norm_t                norm_x,
	output ffn_pkg::norm_t                norm_y,
	output ffn_pkg::norm_t                norm_z,
	output logic [ffn_pkg::IdxW-1:0]      vert_index,
	output logic                          last_corner
);
	import ffn_pkg::*;

	ffn_state_t state_q, state_d;

	coord_t pa_q [3];
	coord_t pb_q [3];
	coord_t pq_q [3];
	logic signed [EdgeW-1:0] e1_q [3];
	logic signed [EdgeW-1:0] e2_q [3];
	logic signed [CrossW-1:0] c_q [3];
	logic [MagW-1:0] r_q [3];
	logic [2:0] neg_q;
	logic [SumW-1:0] sum_q;
	logic [NormW-1:0] nrm_q [3];
	logic [IdxW-1:0] cnt_q;
	logic [1:0] corner_q;
	logic [2:0] step_q;
	logic mul_busy_q;

	// multiplier
	logic mul_start;
	logic [MagW-1:0] mul_a, mul_b;
	logic mul_done;
	logic [MagW+FitW-1:0] mul_p;
	logic [EdgeW-1:0] ua, ub;
	logic sgn;

	ffn_serial_mul #(.AW(MagW), .BW(FitW)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start),
		.a(mul_a), .b(mul_b[FitW-1:0]), .done(mul_done), .p(mul_p)
	);

	// cross product term selection: step 0..5
	logic signed [EdgeW-1:0] fa, fb;
	always_comb begin
		case (step_q)
			3'd0: begin fa = e1_q[1]; fb = e2_q[2]; end
			3'd1: begin fa = e1_q[2]; fb = e2_q[1]; end
			3'd2: begin fa = e1_q[2]; fb = e2_q[0]; end
			3'd3: begin fa = e1_q[0]; fb = e2_q[2]; end
			3'd4: begin fa = e1_q[0]; fb = e2_q[1]; end
			3'd5: begin fa = e1_q[1]; fb = e2_q[0]; end
			default: begin fa = '0; fb = '0; end
		endcase
		ua  = fa[EdgeW-1] ? EdgeW'(-fa) : EdgeW'(fa);
		ub  = fb[EdgeW-1] ? EdgeW'(-fb) : EdgeW'(fb);
		sgn = fa[EdgeW-1] ^ fb[EdgeW-1];
	end

	logic [1:0] sq_i;
	assign sq_i = step_q[1:0];

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (state_q == ST_MUL) begin
			mul_a = MagW'(ua);
			mul_b = MagW'(ub);
		end else begin
			mul_a = r_q[sq_i];
			mul_b = r_q[sq_i];
		end
	end
	assign mul_start = !mul_busy_q && (state_q == ST_MUL || state_q == ST_SQ);

	logic signed [CrossW-1:0] prod_s;
	assign prod_s = sgn ? -CrossW'(mul_p[CrossW-1:0]) : CrossW'(mul_p[CrossW-1:0]);

	// magnitude max
	logic [MagW-1:0] mx;
	assign mx = (r_q[0] > r_q[1]) ? ((r_q[0] > r_q[2]) ? r_q[0] : r_q[2])
	                              : ((r_q[1] > r_q[2]) ? r_q[1] : r_q[2]);

	// square root: restoring, two bits of radicand per step
	logic [SumW-1:0] rad_q;
	logic [RootW+1:0] rem_q;
	logic [RootW-1:0] root_q;
	logic [5:0] it_q;
	logic [RootW+1:0] rem_sh, trial;
	logic [RootW-1:0] root_nx;
	assign rem_sh  = {rem_q[RootW-1:0], rad_q[SumW-1 -: 2]};
	assign trial   = {root_q, 2'b01};
	assign root_nx = {root_q[RootW-2:0], rem_sh >= trial};

	// divider: q = floor((r*2^15 + L) / (2L))
	logic [NumW-1:0] num_q;
	logic [RootW+1:0] drem_q;
	logic [QuoW+1:0] quo_q;
	logic [RootW+1:0] den;
	logic [RootW+1:0] drem_sh;
	assign den     = {1'b0, root_q, 1'b0};
	assign drem_sh = {drem_q[RootW:0], num_q[NumW-1]};

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_MUL;
			ST_MUL:   if (mul_done && step_q == 3'd5) state_d = ST_MAG;
			ST_MAG:   state_d = (c_q[0] == '0 && c_q[1] == '0 && c_q[2] == '0)
				? ST_EMIT : ST_SHIFT;
			ST_SHIFT: if (mx < MagW'(1 << FitW)) state_d = ST_SQ;
			ST_SQ:    if (mul_done && step_q == 3'd2) state_d = ST_ROOT;
			ST_ROOT:  if (it_q == 6'd30) state_d = ST_DIV;
			ST_DIV:   if (it_q == 6'(NumW - 1) && step_q == 3'd2) state_d = ST_EMIT;
			ST_EMIT:  if (out_ready && corner_q == 2'd2) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			corner_q   <= '0;
			step_q     <= '0;
			it_q       <= '0;
			mul_busy_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (mul_start) mul_busy_q <= 1'b1;
			else if (mul_done) mul_busy_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (in_valid && new_mesh) cnt_q <= '0;
				end
				ST_MUL: if (mul_done) step_q <= (step_q == 3'd5) ? 3'd0 : step_q + 1'b1;
				ST_SQ: if (mul_done) begin
					step_q <= (step_q == 3'd2) ? 3'd0 : step_q + 1'b1;
					it_q   <= '0;
				end
				ST_ROOT: it_q <= (it_q == 6'd30) ? 6'd0 : it_q + 1'b1;
				ST_DIV: if (it_q == 6'(NumW - 1)) begin
					it_q   <= '0;
					step_q <= step_q + 1'b1;
				end else it_q <= it_q + 1'b1;
				ST_EMIT: if (out_ready) begin
					corner_q <= (corner_q == 2'd2) ? 2'd0 : corner_q + 1'b1;
					cnt_q    <= cnt_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (in_valid) begin
				pa_q[0] <= ax; pa_q[1] <= ay; pa_q[2] <= az;
				pb_q[0] <= bx; pb_q[1] <= by; pb_q[2] <= bz;
				pq_q[0] <= qx; pq_q[1] <= qy; pq_q[2] <= qz;
				e1_q[0] <= EdgeW'(bx) - EdgeW'(ax);
				e1_q[1] <= EdgeW'(by) - EdgeW'(ay);
				e1_q[2] <= EdgeW'(bz) - EdgeW'(az);
				e2_q[0] <= EdgeW'(qx) - EdgeW'(ax);
				e2_q[1] <= EdgeW'(qy) - EdgeW'(ay);
				e2_q[2] <= EdgeW'(qz) - EdgeW'(az);
				sum_q <= '0;
			end
			ST_MUL: if (mul_done) begin
				if (!step_q[0]) c_q[step_q[2:1]] <= prod_s;
				else c_q[step_q[2:1]] <= c_q[step_q[2:1]] - prod_s;
			end
			ST_MAG: for (int i = 0; i < 3; i++) begin
				neg_q[i] <= c_q[i][CrossW-1];
				r_q[i]   <= c_q[i][CrossW-1] ? MagW'(-c_q[i]) : MagW'(c_q[i]);
				nrm_q[i] <= '0;
			end
			ST_SHIFT: if (!(mx < MagW'(1 << FitW)))
				for (int i = 0; i < 3; i++) r_q[i] <= r_q[i] >> 1;
			ST_SQ: if (mul_done) begin
				sum_q <= sum_q + mul_p[SumW-1:0];
				if (step_q == 3'd2) begin
					rad_q  <= sum_q + mul_p[SumW-1:0];
					rem_q  <= '0;
					root_q <= '0;
				end
			end
			ST_ROOT: begin
				rad_q  <= rad_q << 2;
				root_q <= root_nx;
				if (rem_sh >= trial) rem_q <= rem_sh - trial;
				else rem_q <= rem_sh;
				if (it_q == 6'd30) begin
					num_q  <= NumW'({r_q[0][FitW-1:0], {QuoW{1'b0}}}) + NumW'(root_nx);
					drem_q <= '0;
					quo_q  <= '0;
				end
			end
			ST_DIV: begin
				if (it_q == 6'(NumW - 1)) begin
					nrm_q[step_q[1:0]] <= neg_q[step_q[1:0]]
						? NormW'(-{quo_q[QuoW-1:0], drem_sh >= den})
						: NormW'({quo_q[QuoW-1:0], drem_sh >= den});
					num_q  <= NumW'({r_q[step_q[1:0] + 2'd1][FitW-1:0], {QuoW{1'b0}}})
						+ NumW'(root_q);
					drem_q <= '0;
					quo_q  <= '0;
				end else begin
					num_q <= num_q << 1;
					if (drem_sh >= den) begin
						drem_q <= drem_sh - den;
						quo_q  <= {quo_q[QuoW:0], 1'b1};
					end else begin
						drem_q <= drem_sh;
						quo_q  <= {quo_q[QuoW:0], 1'b0};
					end
				end
			end
			default: ;
		endcase
	end

	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = state_q == ST_EMIT;
	assign pos_x = (corner_q == 2'd0) ? pa_q[0] : (corner_q == 2'd1) ? pb_q[0] : pq_q[0];
	assign pos_y = (corner_q == 2'd0) ? pa_q[1] : (corner_q == 2'd1) ? pb_q[1] : pq_q[1];
	assign pos_z = (corner_q == 2'd0) ? pa_q[2] : (corner_q == 2'd1) ? pb_q[2] : pq_q[2];
	assign norm_x = nrm_q[0];
	assign norm_y = nrm_q[1];
	assign norm_z = nrm_q[2];
	assign vert_index  = cnt_q;
	assign last_corner = corner_q == 2'd2;

	a_corner_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> corner_q == 2'd0) else $error("corner not reset");
	a_emit_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("accept while emitting");
	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last_corner |=> state_q == ST_IDLE)
		else $error("no return to idle");
endmodule
